/* design/vrt_pkg.sv */
// Shared constants and types for the voxel ray traversal block.
package vrt_pkg;

  // Default grid size
  localparam int GRID_X_DEF = 64;
  localparam int GRID_Y_DEF = 64;
  localparam int GRID_Z_DEF = 32;

  // Voxel codes
  localparam logic [7:0] EMPTY_CODE  = 8'd32;
  localparam logic [7:0] BORDER_CODE = 8'd45;

  // Register reset values and indexes
  localparam logic [21:0] MAX_DIST_RST = 22'd1638400;
  localparam logic [15:0] BORDER_RST   = 16'd3277;
  localparam int          CFG_IDX_W    = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BORDER   = 1'd1;

  // Near-vertical ray limits
  localparam logic signed [15:0] VERT_MIN = 16'sd16220;
  localparam logic [15:0]        FLAT_MAX = 16'd16;

  // Saturated crossing time of an axis that never steps
  localparam logic [31:0] RECIP_INF = 32'hFFFF_FFFF;

  // Signed voxel coordinate, holds -1 up to the largest grid size
  localparam int COORD_W = 12;

  // Port widths
  localparam int IN_DATA_W  = 144;
  localparam int OUT_DATA_W = 32;

  // Divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* design/vrt_ram.sv */
// Generic single-port-write, registered-read RAM.
module vrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/vrt_div.sv */
// Bit-serial reciprocal unit: quot = floor(2^30 / divisor), one bit a cycle.
module vrt_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [15:0]         divisor,
  output vrt_pkg::div_stat_t  stat,
  output logic [30:0]         quot
);
  import vrt_pkg::*;

  logic        busy;
  logic        done;
  logic [4:0]  cnt;
  logic [16:0] rem;
  logic [15:0] dvs;
  logic [16:0] rem_sh;
  logic        qbit;
  logic [16:0] rem_next;

  // Shift in the next dividend bit (only the top bit is set) and try subtract
  always_comb begin
    rem_sh   = {rem[15:0], (cnt == 5'd30)};
    qbit     = (rem_sh >= {1'b0, dvs});
    rem_next = qbit ? (rem_sh - {1'b0, dvs}) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 5'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd30;
        rem  <= 17'd0;
        quot <= 31'd0;
        dvs  <= divisor;
      end else if (busy) begin
        rem  <= rem_next;
        quot <= {quot[29:0], qbit};
        cnt  <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

/* design/vrt_mul.sv */
// Shared 32x32 multiplier with registered product.
module vrt_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] prod
);
  import vrt_pkg::*;

  always_ff @(posedge clk) begin
    prod <= 64'(a) * 64'(b);
  end

endmodule

/* design/voxel_ray_traversal.sv */
// Voxel grid store with an Amanatides-Woo ray caster, top level.
// Write word: stored in the voxel RAM on accept if inside the grid, no result. Trace word:
// a bad origin or zero direction goes straight to the result, else bit-serial reciprocals
// of the moving axes and their crossing setup, voxel steps (z planes on the near-vertical
// path) with one voxel RAM read each, and a border test of the hit. One word is worked on
// at a time; the result sits in an output register. Reset: synchronous; afterwards the
// voxel RAM is cleared one entry a cycle, 131072 entries by default.
module voxel_ray_traversal #(
  parameter int GRID_X = vrt_pkg::GRID_X_DEF,
  parameter int GRID_Y = vrt_pkg::GRID_Y_DEF,
  parameter int GRID_Z = vrt_pkg::GRID_Z_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // slave: tdata = voxel_x[5:0], voxel_y[11:6], voxel_z[16:12], voxel_value[24:17],
  // pos_x[46:25], pos_y[68:47], pos_z[89:69], dir_x[105:90], dir_y[121:106],
  // dir_z[137:122], zero fill; tuser = op
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [vrt_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic                           s_tuser,
  // master: tdata = hit_code[7:0], hit_distance[29:8], zero fill; tuser = hit_flag
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [vrt_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                           m_tuser,
  // configuration write port
  input  logic                           cfg_wr_en,
  input  logic [vrt_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [21:0]                    cfg_data
);
  import vrt_pkg::*;

  localparam int DEPTH = GRID_X * GRID_Y * GRID_Z;
  localparam int AW    = $clog2(DEPTH);
  localparam logic signed [COORD_W-1:0] LIM_X = COORD_W'(GRID_X);
  localparam logic signed [COORD_W-1:0] LIM_Y = COORD_W'(GRID_Y);
  localparam logic signed [COORD_W-1:0] LIM_Z = COORD_W'(GRID_Z);

  // Sequencer states
  localparam logic [4:0] S_CLEAR = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_CHK0  = 5'd2;
  localparam logic [4:0] S_ORG   = 5'd3;
  localparam logic [4:0] S_DIV   = 5'd4;
  localparam logic [4:0] S_DWAIT = 5'd5;
  localparam logic [4:0] S_TMUL  = 5'd6;
  localparam logic [4:0] S_TSET  = 5'd7;
  localparam logic [4:0] S_WALK0 = 5'd8;
  localparam logic [4:0] S_STEP  = 5'd9;
  localparam logic [4:0] S_SCHK  = 5'd10;
  localparam logic [4:0] S_ZINIT = 5'd11;
  localparam logic [4:0] S_ZMUL  = 5'd12;
  localparam logic [4:0] S_ZDIST = 5'd13;
  localparam logic [4:0] S_ZCHK  = 5'd14;
  localparam logic [4:0] S_BMUL  = 5'd15;
  localparam logic [4:0] S_BEVAL = 5'd16;
  localparam logic [4:0] S_DONE  = 5'd17;

  logic [4:0]  state;
  logic [AW-1:0] clr_addr;

  // config registers
  logic [21:0] max_dist;
  logic [15:0] border;

  // ray registers
  logic [21:0] pos_x, pos_y;
  logic [20:0] pos_z;
  logic [15:0] plo [0:2];
  logic signed [15:0] dir [0:2];
  logic [15:0] mag [0:2];
  logic signed [COORD_W-1:0] c [0:2];
  logic signed [COORD_W-1:0] zs;
  logic [32:0] t [0:2];
  logic [31:0] dt [0:2];
  logic [32:0] ray_dist;
  logic [1:0]  k;
  logic [1:0]  cnt;
  logic        vert;

  // result registers
  logic        res_flag;
  logic [7:0]  res_code;
  logic [21:0] res_dist;

  // input word fields
  logic [5:0]  in_vx, in_vy;
  logic [4:0]  in_vz;
  logic [7:0]  in_val;

  assign in_vx  = s_tdata[5:0];
  assign in_vy  = s_tdata[11:6];
  assign in_vz  = s_tdata[16:12];
  assign in_val = s_tdata[24:17];

  // Linear voxel address
  function automatic logic [AW-1:0] addr_of(input logic signed [COORD_W-1:0] x,
                                            input logic signed [COORD_W-1:0] y,
                                            input logic signed [COORD_W-1:0] z);
    logic [AW-1:0] a;
    a = (AW'(unsigned'(z)) * AW'(GRID_Y) + AW'(unsigned'(y))) * AW'(GRID_X)
        + AW'(unsigned'(x));
    return a;
  endfunction

  // Next voxel step: smallest crossing time, ties to the later axis
  logic [1:0]  ax;
  logic signed [COORD_W-1:0] cn;
  logic signed [COORD_W-1:0] lim_ax;
  logic signed [COORD_W-1:0] sx, sy, sz;
  logic        cn_out;

  always_comb begin
    if (t[0] < t[1]) begin
      ax = (t[0] < t[2]) ? 2'd0 : 2'd2;
    end else begin
      ax = (t[1] < t[2]) ? 2'd1 : 2'd2;
    end
    cn = dir[ax][15] ? (c[ax] - COORD_W'(1)) : (c[ax] + COORD_W'(1));
    case (ax)
      2'd0:    lim_ax = LIM_X;
      2'd1:    lim_ax = LIM_Y;
      default: lim_ax = LIM_Z;
    endcase
    cn_out = (cn < 0) || (cn >= lim_ax);
    sx = (ax == 2'd0) ? cn : c[0];
    sy = (ax == 2'd1) ? cn : c[1];
    sz = (ax == 2'd2) ? cn : c[2];
  end

  // Voxel RAM, cleared after reset, written by write words
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;
  logic          wr_in_grid;
  logic          accept;

  assign s_tready   = (state == S_IDLE);
  assign accept     = s_tvalid && s_tready;
  assign wr_in_grid = (32'(in_vx) < 32'(GRID_X)) && (32'(in_vy) < 32'(GRID_Y))
                      && (32'(in_vz) < 32'(GRID_Z));

  always_comb begin
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = EMPTY_CODE;
    end else begin
      ram_we    = accept && !s_tuser && wr_in_grid;
      ram_waddr = addr_of(COORD_W'(in_vx), COORD_W'(in_vy), COORD_W'(in_vz));
      ram_wdata = in_val;
    end
    case (state)
      S_STEP:  ram_raddr = addr_of(sx, sy, sz);
      S_ZDIST: ram_raddr = addr_of(c[0], c[1], zs);
      default: ram_raddr = addr_of(c[0], c[1], c[2]);
    endcase
  end

  vrt_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Shared reciprocal unit
  div_stat_t   div_stat;
  logic [30:0] div_q;
  logic        div_start;

  assign div_start = (state == S_DIV) && (mag[k] != 16'd0);

  vrt_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .divisor (mag[k]),
    .stat    (div_stat),
    .quot    (div_q)
  );

  // Shared multiplier operand select
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [16:0] off;

  always_comb begin
    off = dir[k][15] ? {1'b0, plo[k]} : (17'h10000 - {1'b0, plo[k]});
    case (state)
      S_TMUL: begin
        mul_a = 32'(off);
        mul_b = dt[k];
      end
      S_ZMUL: begin
        mul_a = (32'(unsigned'(zs)) << 16) - 32'(pos_z);
        mul_b = dt[2];
      end
      default: begin
        mul_a = ray_dist[31:0];
        mul_b = 32'(mag[k]);
      end
    endcase
  end

  vrt_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // Border test of one hit coordinate
  logic [15:0] bm, bv;
  logic [16:0] bdist;
  logic        near;
  logic [1:0]  cnt_sum;

  always_comb begin
    bm      = prod[29:14];
    bv      = dir[k][15] ? (plo[k] - bm) : (plo[k] + bm);
    bdist   = bv[15] ? (17'h10000 - {1'b0, bv}) : {1'b0, bv};
    near    = bdist < {1'b0, border};
    cnt_sum = cnt + {1'b0, near};
  end

  // Input word decode
  logic signed [15:0] in_dx, in_dy, in_dz;
  logic        org_out;
  logic        dir_zero;

  assign in_dx = s_tdata[105:90];
  assign in_dy = s_tdata[121:106];
  assign in_dz = s_tdata[137:122];
  assign org_out  = (32'(pos_x) >= (32'(GRID_X) << 16)) || (32'(pos_y) >= (32'(GRID_Y) << 16))
                    || (32'(pos_z) >= (32'(GRID_Z) << 16));
  assign dir_zero = (dir[0] == 16'sd0) && (dir[1] == 16'sd0) && (dir[2] == 16'sd0);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_dist <= MAX_DIST_RST;
      border   <= BORDER_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_MAX_DIST: max_dist <= cfg_data;
        CFG_BORDER:   border   <= cfg_data[15:0];
        default:      ;
      endcase
    end
  end

  // Result valid: raised when a result is loaded, dropped when it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == S_DONE) && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept && s_tuser) begin
            pos_x  <= s_tdata[46:25];
            pos_y  <= s_tdata[68:47];
            pos_z  <= s_tdata[89:69];
            plo[0] <= s_tdata[40:25];
            plo[1] <= s_tdata[62:47];
            plo[2] <= s_tdata[84:69];
            dir[0] <= in_dx;
            dir[1] <= in_dy;
            dir[2] <= in_dz;
            mag[0] <= in_dx[15] ? (16'd0 - in_dx) : in_dx;
            mag[1] <= in_dy[15] ? (16'd0 - in_dy) : in_dy;
            mag[2] <= in_dz[15] ? (16'd0 - in_dz) : in_dz;
            c[0]   <= COORD_W'(s_tdata[46:41]);
            c[1]   <= COORD_W'(s_tdata[68:63]);
            c[2]   <= COORD_W'(s_tdata[89:85]);
            state  <= S_CHK0;
          end
        end
        S_CHK0: begin
          vert <= (dir[2] > VERT_MIN) && (mag[0] <= FLAT_MAX) && (mag[1] <= FLAT_MAX);
          res_flag <= 1'b0;
          res_code <= EMPTY_CODE;
          res_dist <= max_dist;
          if (org_out || dir_zero) begin
            state <= S_DONE;
          end else begin
            state <= S_ORG;
          end
        end
        S_ORG: begin
          if (ram_rdata != EMPTY_CODE) begin
            res_flag <= 1'b1;
            res_code <= ram_rdata;
            res_dist <= 22'd0;
            ray_dist <= 33'd0;
            k        <= 2'd0;
            cnt      <= 2'd0;
            state    <= S_BMUL;
          end else begin
            k     <= vert ? 2'd2 : 2'd0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (mag[k] == 16'd0) begin
            t[k]  <= {1'b0, RECIP_INF};
            dt[k] <= RECIP_INF;
            if (k == 2'd2) begin
              state <= S_WALK0;
            end else begin
              k <= k + 2'd1;
            end
          end else begin
            state <= S_DWAIT;
          end
        end
        S_DWAIT: begin
          if (div_stat.done) begin
            dt[k] <= 32'(div_q);
            state <= vert ? S_ZINIT : S_TMUL;
          end
        end
        S_TMUL: begin
          state <= S_TSET;
        end
        S_TSET: begin
          t[k] <= prod[48:16];
          if (k == 2'd2) begin
            state <= S_WALK0;
          end else begin
            k     <= k + 2'd1;
            state <= S_DIV;
          end
        end
        S_WALK0: begin
          state <= (max_dist == 22'd0) ? S_DONE : S_STEP;
        end
        // one voxel step; the RAM read of the new voxel is issued here
        S_STEP: begin
          ray_dist <= t[ax];
          t[ax]    <= t[ax] + 33'(dt[ax]);
          c[ax]    <= cn;
          if (cn_out || (t[ax] > 33'(max_dist))) begin
            state <= S_DONE;
          end else begin
            state <= S_SCHK;
          end
        end
        S_SCHK: begin
          if (ram_rdata != EMPTY_CODE) begin
            res_flag <= 1'b1;
            res_code <= ram_rdata;
            res_dist <= ray_dist[21:0];
            k        <= 2'd0;
            cnt      <= 2'd0;
            state    <= S_BMUL;
          end else if (ray_dist < 33'(max_dist)) begin
            state <= S_STEP;
          end else begin
            state <= S_DONE;
          end
        end
        // z-only walk for near-vertical rays
        S_ZINIT: begin
          zs <= c[2] + COORD_W'(1);
          state <= ((c[2] + COORD_W'(1)) >= LIM_Z) ? S_DONE : S_ZMUL;
        end
        S_ZMUL: begin
          state <= S_ZDIST;
        end
        S_ZDIST: begin
          ray_dist <= prod[48:16];
          state <= (prod[48:16] >= 33'(max_dist)) ? S_DONE : S_ZCHK;
        end
        S_ZCHK: begin
          if (ram_rdata != EMPTY_CODE) begin
            res_flag <= 1'b1;
            res_code <= ram_rdata;
            res_dist <= ray_dist[21:0];
            k        <= 2'd0;
            cnt      <= 2'd0;
            state    <= S_BMUL;
          end else begin
            zs    <= zs + COORD_W'(1);
            state <= ((zs + COORD_W'(1)) >= LIM_Z) ? S_DONE : S_ZMUL;
          end
        end
        // border test, one axis per pass through the multiplier
        S_BMUL: begin
          state <= S_BEVAL;
        end
        S_BEVAL: begin
          cnt <= cnt_sum;
          if (k == 2'd2) begin
            if (cnt_sum >= 2'd2) begin
              res_code <= BORDER_CODE;
            end
            state <= S_DONE;
          end else begin
            k     <= k + 2'd1;
            state <= S_BMUL;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tuser  <= res_flag;
            m_tdata  <= {2'b00, res_dist, res_code};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // No word is taken while the RAM is being cleared
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !s_tready)
    else $error("word accepted during RAM clear");

  // A miss always reports the empty code
  a_miss_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[7:0] == EMPTY_CODE)
    else $error("miss with non-empty code");

  // The walk only reads voxels inside the grid
  a_walk_in_grid: assert property (@(posedge clk) disable iff (rst)
    state == S_SCHK |-> c[0] >= 0 && c[0] < LIM_X && c[1] >= 0 && c[1] < LIM_Y
                        && c[2] >= 0 && c[2] < LIM_Z)
    else $error("voxel step left the grid unnoticed");

  // The reciprocal unit only runs while the sequencer waits for it
  a_div_owned: assert property (@(posedge clk) disable iff (rst)
    div_stat.busy |-> state == S_DWAIT)
    else $error("divider busy outside its wait state");

endmodule
